>>> design/elfv_pkg.sv
package elfv_pkg;

  localparam logic [31:0] PT_LOAD       = 32'd1;
  localparam logic [31:0] PT_LOADER_REQ = 32'd3;
  localparam int unsigned PF_X          = 0;
  localparam int unsigned PF_W          = 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE  = 3'd0,
    CFG_ENTRY_ADDR  = 3'd1,
    CFG_USER_LIMIT  = 3'd2,
    CFG_GUARD_BASE  = 3'd3,
    CFG_STACK_TOP   = 3'd4,
    CFG_PAGE_LIMIT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_PERM    = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_NOMEM   = 3'd5
  } status_t;

  typedef struct packed {
    logic    eval1;
    logic    eval2;
    logic    scan_rd;
    logic    commit;
    logic    finish;
    logic    set_err;
    status_t err_code;
  } dp_cmd_t;

  typedef struct packed {
    status_t pre_err;
    logic    pre_go;
    status_t chk_err;
    logic    seg_zero;
    logic    overlap;
    logic    nomem;
    logic    out_busy;
  } dp_stat_t;

endpackage

>>> design/elfv_in_if.sv
interface elfv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seg_type;
  logic [2:0]  seg_flags;
  logic [63:0] seg_offset;
  logic [63:0] virt_addr;
  logic [63:0] file_bytes;
  logic [63:0] mem_bytes;
  logic        last_header;

  modport source (output valid, seg_type, seg_flags, seg_offset, virt_addr, file_bytes,
                  mem_bytes, last_header, input ready);
  modport sink (input valid, seg_type, seg_flags, seg_offset, virt_addr, file_bytes,
                mem_bytes, last_header, output ready);
endinterface

>>> design/elfv_out_if.sv
interface elfv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        done_res;
  logic [16:0] page_total;
  logic [4:0]  load_count;

  modport source (output valid, status, done_res, page_total, load_count, input ready);
  modport sink (input valid, status, done_res, page_total, load_count, output ready);
endinterface

>>> design/elfv_datapath.sv
module elfv_datapath #(
  parameter int unsigned PAGE_BITS    = 12,
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned IDX_W        = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [elfv_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [elfv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          cap,
  input  logic [31:0]                   seg_type,
  input  logic [2:0]                    seg_flags,
  input  logic [63:0]                   seg_offset,
  input  logic [63:0]                   virt_addr,
  input  logic [63:0]                   file_bytes,
  input  logic [63:0]                   mem_bytes,
  input  logic                          last_header,
  input  elfv_pkg::dp_cmd_t             cmd,
  input  logic [IDX_W-1:0]              scan_addr,
  output elfv_pkg::dp_stat_t            stat,
  output logic                          scan_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic                          out_done,
  output logic [16:0]                   out_pages,
  output logic [4:0]                    out_loads
);
  import elfv_pkg::*;

  localparam int unsigned VPN_W = 64 - PAGE_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [63:0] PAGE_SZ   = 64'd1 << PAGE_BITS;
  localparam logic [63:0] PAGE_MASK = PAGE_SZ - 64'd1;

  logic [63:0] image_size_r, entry_r, user_limit_r, guard_r, stack_top_r;
  logic [15:0] page_limit_r;

  logic [31:0] type_r;
  logic [2:0]  flags_r;
  logic [63:0] off_r, va_r, fsz_r, msz_r;
  logic        last_r;

  logic [63:0] ib_r, ur_r, vend_r;
  logic        off_gt_r, fsz_gt_msz_r, va_low_r, va_ge_ul_r, congr_r, wx_r, ent_ge_r;

  logic [VPN_W-1:0] sp_r, ep_r;
  logic [VPN_W:0]   npg_r;
  logic             ent_in_r;

  logic [VPN_W-1:0] mem_start [MAX_SEGMENTS];
  logic [VPN_W-1:0] mem_end [MAX_SEGMENTS];
  logic [VPN_W-1:0] rd_start_r, rd_end_r;
  logic             cmp_vld_r, ovl_r;

  logic [CNT_W-1:0] hs_r, seg_r;
  logic [16:0]      pages_r;
  logic             ent_cov_r;
  status_t          err_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic        out_done_r;
  logic [16:0] out_pages_r;
  logic [4:0]  out_loads_r;

  logic        hs_full, is_load_go;
  logic [63:0] ea, sa;
  logic        nomem;
  logic [15:0] budget;
  status_t     chk, fin_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= 64'd0;
      entry_r      <= 64'd0;
      user_limit_r <= 64'd140737488355328;
      guard_r      <= 64'd140737488343040;
      stack_top_r  <= 64'd140737488351232;
      page_limit_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_SIZE: image_size_r <= cfg_wdata;
        CFG_ENTRY_ADDR: entry_r      <= cfg_wdata;
        CFG_USER_LIMIT: user_limit_r <= cfg_wdata;
        CFG_GUARD_BASE: guard_r      <= cfg_wdata;
        CFG_STACK_TOP:  stack_top_r  <= cfg_wdata;
        CFG_PAGE_LIMIT: page_limit_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      type_r  <= seg_type;
      flags_r <= seg_flags;
      off_r   <= seg_offset;
      va_r    <= virt_addr;
      fsz_r   <= file_bytes;
      msz_r   <= mem_bytes;
      last_r  <= last_header;
    end
    if (cmd.eval1) begin
      ib_r         <= image_size_r - off_r;
      ur_r         <= user_limit_r - va_r;
      vend_r       <= va_r + msz_r - 64'd1;
      off_gt_r     <= off_r > image_size_r;
      fsz_gt_msz_r <= fsz_r > msz_r;
      va_low_r     <= va_r < PAGE_SZ;
      va_ge_ul_r   <= va_r >= user_limit_r;
      congr_r      <= ((va_r ^ off_r) & PAGE_MASK) != 64'd0;
      wx_r         <= flags_r[PF_W] && flags_r[PF_X];
      ent_ge_r     <= entry_r >= va_r;
    end
    if (cmd.eval2) begin
      sp_r     <= sa[63:PAGE_BITS];
      ep_r     <= ea[63:PAGE_BITS];
      npg_r    <= {1'b0, ea[63:PAGE_BITS]} - {1'b0, sa[63:PAGE_BITS]} + {{VPN_W{1'b0}}, 1'b1};
      ent_in_r <= flags_r[PF_X] && ent_ge_r && (entry_r <= vend_r);
    end
  end

  assign hs_full    = hs_r == CNT_W'(MAX_SEGMENTS);
  assign is_load_go = (type_r == PT_LOAD) && (msz_r != 64'd0);

  assign stat.pre_err = (err_r == ST_OK && (hs_full || type_r == PT_LOADER_REQ)) ?
                        ST_INVALID : ST_OK;
  assign stat.pre_go = (err_r == ST_OK) && !hs_full && is_load_go;

  assign sa = va_r & ~PAGE_MASK;
  assign ea = vend_r & ~PAGE_MASK;

  always_comb begin
    priority if (wx_r)                              chk = ST_PERM;
    else if (off_gt_r || fsz_r > ib_r)              chk = ST_BOUNDS;
    else if (fsz_gt_msz_r)                          chk = ST_BOUNDS;
    else if (va_low_r)                              chk = ST_PERM;
    else if (va_ge_ul_r || msz_r > ur_r)            chk = ST_BOUNDS;
    else if (congr_r)                               chk = ST_BOUNDS;
    else if (ea >= guard_r && sa < stack_top_r)     chk = ST_OVERLAP;
    else                                            chk = ST_OK;
  end
  assign stat.chk_err = chk;

  // Once pages_used sits above the limit every further load is refused.
  assign budget = page_limit_r - pages_r[15:0];
  assign nomem  = (pages_r > {1'b0, page_limit_r}) ||
                  (npg_r > (VPN_W+1)'(budget));

  assign stat.seg_zero = seg_r == '0;
  assign stat.overlap  = ovl_r;
  assign stat.nomem    = nomem;
  assign stat.out_busy = out_valid_r && !out_ready;
  assign scan_last     = ({1'b0, scan_addr} + (IDX_W+1)'(1)) == (IDX_W+1)'(seg_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_start_r <= mem_start[scan_addr];
      rd_end_r   <= mem_end[scan_addr];
    end
    if (cmd.commit && seg_r < CNT_W'(MAX_SEGMENTS)) begin
      mem_start[seg_r[IDX_W-1:0]] <= sp_r;
      mem_end[seg_r[IDX_W-1:0]]   <= ep_r;
    end
  end

  always_comb begin
    fin_status = err_r;
    if (last_r && err_r == ST_OK) begin
      if (seg_r == '0) fin_status = ST_INVALID;
      else if (!ent_cov_r) fin_status = ST_PERM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r        <= '0;
      seg_r       <= '0;
      pages_r     <= '0;
      ent_cov_r   <= 1'b0;
      err_r       <= ST_OK;
      cmp_vld_r   <= 1'b0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.eval2) ovl_r <= 1'b0;
      else if (cmp_vld_r && !(ep_r < rd_start_r || sp_r > rd_end_r)) ovl_r <= 1'b1;
      if (cmd.eval1 && err_r == ST_OK && !hs_full) hs_r <= hs_r + CNT_W'(1);
      if (cmd.set_err) err_r <= cmd.err_code;
      if (cmd.commit) begin
        pages_r   <= pages_r + npg_r[16:0];
        ent_cov_r <= ent_cov_r | ent_in_r;
        if (seg_r < CNT_W'(MAX_SEGMENTS)) seg_r <= seg_r + CNT_W'(1);
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          hs_r      <= '0;
          seg_r     <= '0;
          pages_r   <= '0;
          ent_cov_r <= 1'b0;
          err_r     <= ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= fin_status;
      out_done_r   <= last_r;
      out_pages_r  <= (last_r && fin_status == ST_OK) ? pages_r + 17'd1 : pages_r;
      out_loads_r  <= 5'(seg_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_done   = out_done_r;
  assign out_pages  = out_pages_r;
  assign out_loads  = out_loads_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.finish && out_valid_r && !out_ready))
    else $error("result register overwritten while still held");
  a_image_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && last_r |=> seg_r == '0 && hs_r == '0 && err_r == ST_OK)
    else $error("image state not cleared after the final header");
  a_pages_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !pages_r[16])
    else $error("page count beyond the largest possible limit");
  a_seg_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= CNT_W'(MAX_SEGMENTS) && hs_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment or header count beyond the table depth");

endmodule

>>> design/elfv_ctrl.sv
module elfv_ctrl #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                cap,
  output elfv_pkg::dp_cmd_t   cmd,
  output logic [IDX_W-1:0]    scan_addr,
  input  elfv_pkg::dp_stat_t  stat,
  input  logic                scan_last
);
  import elfv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL1, S_EVAL2, S_SCAN, S_DRAIN, S_BUDGET, S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.err_code = ST_OK;
    in_ready     = 1'b0;
    cap          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cap       = 1'b1;
          state_nxt = S_EVAL1;
        end
      end
      S_EVAL1: begin
        cmd.eval1 = 1'b1;
        if (stat.pre_err != ST_OK) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = stat.pre_err;
        end
        state_nxt = stat.pre_go ? S_EVAL2 : S_FINISH;
      end
      S_EVAL2: begin
        if (stat.chk_err != ST_OK) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = stat.chk_err;
          state_nxt    = S_FINISH;
        end else begin
          cmd.eval2 = 1'b1;
          idx_nxt   = '0;
          state_nxt = stat.seg_zero ? S_BUDGET : S_SCAN;
        end
      end
      S_SCAN: begin
        // One stored range is read a cycle; the compare works on the registered read and sets the overlap flag.
        cmd.scan_rd = 1'b1;
        idx_nxt     = idx_r + IDX_W'(1);
        if (scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_BUDGET;
      S_BUDGET: begin
        if (stat.overlap) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_OVERLAP;
        end else if (stat.nomem) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_NOMEM;
        end else begin
          cmd.commit = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign scan_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !stat.seg_zero)
    else $error("range scan started on an empty table");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cap |=> state_r == S_EVAL1)
    else $error("accepted header not evaluated");
  a_drain_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |=> state_r == S_BUDGET && !cmd.scan_rd)
    else $error("budget check not after the last range compare");

endmodule

>>> design/elf_segment_validator_unit.sv
// ELF64 program header validator. Headers of one image arrive one per transaction, the last
// one marked; each gives one result carrying the sticky status, and the last gives the
// verdict. After acceptance a header that is skipped, rejected by type or count, or arrives
// after an error goes through S_EVAL1 to S_FINISH; a load segment failing a field check
// through S_EVAL1 and S_EVAL2; the first load segment of an image through S_EVAL1, S_EVAL2
// and S_BUDGET; and any other through S_EVAL1, S_EVAL2, S_SCAN, S_DRAIN and S_BUDGET, since
// its page range is compared against the stored ranges one per cycle through the range
// table's single read port. A new header is taken only once the previous one has moved into
// the result register in S_FINISH, which waits while an earlier result is still held, and
// the unit then returns to idle, where the next header can be accepted.
// Configuration writes must be made only while no header is in flight.
module elf_segment_validator_unit #(
  parameter int unsigned PAGE_BITS    = 12,
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [elfv_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [elfv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  elfv_in_if.sink                         in_hdr,
  elfv_out_if.source                      out_res
);
  import elfv_pkg::*;

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             cap, scan_last;
  logic [IDX_W-1:0] scan_addr;

  elfv_ctrl #(.IDX_W(IDX_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_hdr.valid),
    .in_ready  (in_hdr.ready),
    .cap       (cap),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .stat      (stat),
    .scan_last (scan_last)
  );

  elfv_datapath #(
    .PAGE_BITS    (PAGE_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .cap         (cap),
    .seg_type    (in_hdr.seg_type),
    .seg_flags   (in_hdr.seg_flags),
    .seg_offset  (in_hdr.seg_offset),
    .virt_addr   (in_hdr.virt_addr),
    .file_bytes  (in_hdr.file_bytes),
    .mem_bytes   (in_hdr.mem_bytes),
    .last_header (in_hdr.last_header),
    .cmd         (cmd),
    .scan_addr   (scan_addr),
    .stat        (stat),
    .scan_last   (scan_last),
    .out_ready   (out_res.ready),
    .out_valid   (out_res.valid),
    .out_status  (out_res.status),
    .out_done    (out_res.done_res),
    .out_pages   (out_res.page_total),
    .out_loads   (out_res.load_count)
  );

endmodule
